>>> hw/rtl/s_curve_stepper_ramp_core_macros.svh
`ifndef S_CURVE_STEPPER_RAMP_CORE_MACROS_SVH
`define S_CURVE_STEPPER_RAMP_CORE_MACROS_SVH

// check that holds at every clock edge out of reset
`define SCSR_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define SCSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/scsr_pkg.sv
package scsr_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_REL  = 2'd1,
    CMD_ABS  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_t;

endpackage

>>> hw/rtl/scsr_in_if.sv
interface scsr_in_if;
  import scsr_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [7:0]         table_index;
  logic [15:0]        table_value;
  logic signed [31:0] steps;
  logic [15:0]        single_step_reload;

  modport source (
    output valid, command, table_index, table_value, steps, single_step_reload,
    input  ready
  );

  modport sink (
    input  valid, command, table_index, table_value, steps, single_step_reload,
    output ready
  );
endinterface

>>> hw/rtl/scsr_out_if.sv
interface scsr_out_if;
  import scsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [15:0]        reload;
  logic [14:0]        compare;
  logic               direction;
  logic               timer_on;
  logic               moving;
  phase_t             phase;
  logic signed [31:0] position;

  modport source (
    output valid, reload, compare, direction, timer_on, moving, phase, position,
    input  ready
  );

  modport sink (
    input  valid, reload, compare, direction, timer_on, moving, phase, position,
    output ready
  );
endinterface

>>> hw/rtl/s_curve_stepper_ramp_core.sv
// the result of an accepted transaction is registered and offered on out_ch once the skid register is empty
// throughput: one transaction per cycle while the skid register is empty, set by the single registered pass and
//   the registered ramp table read
// a skid register keeps the input open for one more transaction while out_ch stalls
// reset: synchronous, active low; clears phase, counters, position and handshake state
// ramp table contents are not cleared and must be loaded before a move reads them
`include "s_curve_stepper_ramp_core_macros.svh"

module s_curve_stepper_ramp_core #(
  parameter int RAMP_STEPS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  scsr_in_if.sink      in_ch,
  scsr_out_if.source   out_ch
);
  import scsr_pkg::*;

  localparam int          AW       = (RAMP_STEPS > 1) ? $clog2(RAMP_STEPS) : 1;
  localparam logic [31:0] RAMP_W   = 32'(RAMP_STEPS);
  localparam logic [31:0] RAMP_2W  = 32'(2 * RAMP_STEPS);
  localparam logic [AW-1:0] LAST_IDX = AW'(RAMP_STEPS - 1);

  typedef struct packed {
    logic [15:0]        reload;
    logic               direction;
    logic               timer_on;
    logic               moving;
    phase_t             phase;
    logic signed [31:0] position;
  } result_t;

  function automatic logic [AW-1:0] clamp_idx(input logic [31:0] v);
    logic [AW-1:0] r;
    r = (v >= RAMP_W) ? LAST_IDX : v[AW-1:0];
    return r;
  endfunction

  // ramp table
  logic [15:0] ramp_mem [RAMP_STEPS];
  logic [15:0] mem_q_r;

  // move state
  phase_t             phase_r, phase_nxt;
  logic               dir_r, dir_nxt;
  logic [31:0]        step_cnt_r, step_cnt_nxt;
  logic [31:0]        total_r, total_nxt;
  logic [31:0]        accel_lim_r, accel_lim_nxt;
  logic [31:0]        decel_beg_r, decel_beg_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  logic               moving_r, moving_nxt;
  logic               timer_on_r, timer_on_nxt;
  logic [15:0]        reload_hold_r, reload_hold_nxt;
  logic               use_mem_r;

  // handshake
  logic    a_v_r;
  logic    skid_v_r;
  result_t skid_r;

  logic          accept;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          set_single;
  logic [31:0]   idx_ext;
  logic [31:0]   travel;
  logic [31:0]   mag;
  logic [31:0]   sc_inc;
  logic signed [31:0] pos_step;
  logic [15:0]   reload_cur;
  result_t       a_res;
  result_t       out_res;
  logic          tick_stop;
  logic          tick_move;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && in_ch.ready;

  assign idx_ext  = {24'd0, in_ch.table_index};
  assign travel   = (in_ch.command == CMD_REL) ? in_ch.steps : in_ch.steps - pos_r;
  assign mag      = travel[31] ? (~travel + 32'd1) : travel;
  assign sc_inc   = step_cnt_r + 32'd1;
  assign pos_step = dir_r ? pos_r - 32'sd1 : pos_r + 32'sd1;

  always_comb begin
    phase_nxt     = phase_r;
    dir_nxt       = dir_r;
    step_cnt_nxt  = step_cnt_r;
    total_nxt     = total_r;
    accel_lim_nxt = accel_lim_r;
    decel_beg_nxt = decel_beg_r;
    pos_nxt       = pos_r;
    moving_nxt    = moving_r;
    timer_on_nxt  = timer_on_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    set_single    = 1'b0;
    unique case (in_ch.command) inside
      CMD_LOAD: begin
        wr_en = (idx_ext < RAMP_W);
      end
      CMD_REL, CMD_ABS: begin
        dir_nxt      = travel[31];
        total_nxt    = mag;
        step_cnt_nxt = 32'd0;
        timer_on_nxt = 1'b1;
        if (mag == 32'd0) begin
          phase_nxt = PH_STOP;
        end else if (mag == 32'd1) begin
          moving_nxt    = 1'b1;
          accel_lim_nxt = 32'd1;
          decel_beg_nxt = 32'd0;
          phase_nxt     = PH_DECEL;
          set_single    = 1'b1;
        end else begin
          moving_nxt = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = '0;
          if (mag <= RAMP_2W) begin
            accel_lim_nxt = {1'b0, mag[31:1]};
            decel_beg_nxt = {1'b0, mag[31:1]};
          end else begin
            accel_lim_nxt = RAMP_W;
            decel_beg_nxt = mag - RAMP_W;
          end
          phase_nxt = PH_ACCEL;
        end
      end
      CMD_TICK: begin
        unique case (phase_r)
          PH_STOP: begin
            step_cnt_nxt = 32'd0;
            timer_on_nxt = 1'b0;
            moving_nxt   = 1'b0;
          end
          PH_ACCEL: begin
            step_cnt_nxt = sc_inc;
            pos_nxt      = pos_step;
            if (sc_inc < accel_lim_r) begin
              rd_en   = 1'b1;
              rd_addr = clamp_idx(sc_inc);
            end else if (sc_inc >= decel_beg_r) begin
              rd_en     = 1'b1;
              rd_addr   = clamp_idx(step_cnt_r);
              phase_nxt = PH_DECEL;
            end else if (sc_inc >= RAMP_W) begin
              rd_en     = 1'b1;
              rd_addr   = LAST_IDX;
              phase_nxt = PH_RUN;
            end
          end
          PH_RUN: begin
            step_cnt_nxt = sc_inc;
            pos_nxt      = pos_step;
            if (sc_inc >= decel_beg_r) begin
              rd_en     = 1'b1;
              rd_addr   = LAST_IDX;
              phase_nxt = PH_DECEL;
            end
          end
          PH_DECEL: begin
            step_cnt_nxt = sc_inc;
            pos_nxt      = pos_step;
            if (sc_inc < total_r) begin
              rd_en   = 1'b1;
              rd_addr = clamp_idx(total_r - sc_inc);
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          default: begin
            phase_nxt = PH_STOP;
          end
        endcase
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // reload after the last accepted transaction
  assign reload_cur      = use_mem_r ? mem_q_r : reload_hold_r;
  assign reload_hold_nxt = set_single ? in_ch.single_step_reload : reload_cur;

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      ramp_mem[idx_ext[AW-1:0]] <= in_ch.table_value;
    end
    if (accept && rd_en) begin
      mem_q_r <= ramp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_STOP;
      dir_r         <= 1'b0;
      step_cnt_r    <= 32'd0;
      total_r       <= 32'd0;
      accel_lim_r   <= 32'd0;
      decel_beg_r   <= 32'd0;
      pos_r         <= 32'sd0;
      moving_r      <= 1'b0;
      timer_on_r    <= 1'b0;
      reload_hold_r <= 16'd0;
      use_mem_r     <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      dir_r         <= dir_nxt;
      step_cnt_r    <= step_cnt_nxt;
      total_r       <= total_nxt;
      accel_lim_r   <= accel_lim_nxt;
      decel_beg_r   <= decel_beg_nxt;
      pos_r         <= pos_nxt;
      moving_r      <= moving_nxt;
      timer_on_r    <= timer_on_nxt;
      reload_hold_r <= reload_hold_nxt;
      use_mem_r     <= rd_en;
    end
  end

  // result of the newest transaction sits in the state registers
  always_comb begin
    a_res.reload    = reload_cur;
    a_res.direction = dir_r;
    a_res.timer_on  = timer_on_r;
    a_res.moving    = moving_r;
    a_res.phase     = phase_r;
    a_res.position  = pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (accept) begin
        a_v_r <= 1'b1;
      end else if (!skid_v_r && out_ch.ready) begin
        a_v_r <= 1'b0;
      end
      if (skid_v_r) begin
        if (out_ch.ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (accept && a_v_r && !out_ch.ready) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && accept && a_v_r && !out_ch.ready) begin
      skid_r <= a_res;
    end
  end

  assign out_res          = skid_v_r ? skid_r : a_res;
  assign out_ch.valid     = skid_v_r || a_v_r;
  assign out_ch.reload    = out_res.reload;
  assign out_ch.compare   = out_res.reload[15:1];
  assign out_ch.direction = out_res.direction;
  assign out_ch.timer_on  = out_res.timer_on;
  assign out_ch.moving    = out_res.moving;
  assign out_ch.phase     = out_res.phase;
  assign out_ch.position  = out_res.position;

  assign tick_stop = accept && (in_ch.command == CMD_TICK) && (phase_r == PH_STOP);
  assign tick_move = accept && (in_ch.command == CMD_TICK) && (phase_r != PH_STOP);

  `SCSR_ASSERT_ALWAYS(a_skid_order, !skid_v_r || a_v_r, "skid holds data without a newer result")
  `SCSR_ASSERT_ALWAYS(a_phase_moving, (phase_r == PH_STOP) || (moving_r && timer_on_r), "active phase without moving and timer")
  `SCSR_ASSERT_ALWAYS(a_accel_lim, accel_lim_r <= RAMP_W, "accelerate limit beyond ramp table")
  `SCSR_ASSERT_NEXT(a_tick_stop, tick_stop, !timer_on_r && !moving_r && (step_cnt_r == 32'd0), "stop tick left timer running")
  `SCSR_ASSERT_NEXT(a_tick_pos, tick_move, (32'(pos_r - $past(pos_r)) == 32'd1) || (32'($past(pos_r) - pos_r) == 32'd1), "tick moved position by other than one step")

endmodule

>>> verif/s_curve_stepper_ramp_core_tb.sv
module s_curve_stepper_ramp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scsr_pkg::*;

  localparam int RAMP_STEPS = 256;

  typedef struct {
    cmd_t        command;
    bit [7:0]    table_index;
    bit [15:0]   table_value;
    bit [31:0]   steps;
    bit [15:0]   single_step_reload;
  } ramp_cmd_s;

  typedef struct {
    logic [15:0] reload;
    logic [14:0] compare;
    logic        direction;
    logic        timer_on;
    logic        moving;
    phase_t      phase;
    logic [31:0] position;
  } ramp_state_s;

  class ramp_scoreboard #(int DEPTH = 256);
    localparam bit [31:0] LAST = DEPTH - 1;

    bit [15:0]   ramp[DEPTH];
    phase_t      ph;
    bit          dir;
    bit [31:0]   step_cnt;
    bit [31:0]   total;
    bit [31:0]   accel_lim;
    bit [31:0]   decel_at;
    bit [15:0]   reload;
    bit [31:0]   pos;
    bit          moving;
    bit          timer_on;

    ramp_state_s expected_states[$];
    int          errors;
    int          commands;
    int          checked;
    int          moves;
    int          run_entries;
    int          stop_ticks;

    function new();
      ph = PH_STOP;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("%0t mismatch: %s", $time, msg);
    endtask

    function bit [15:0] ramp_at(bit [31:0] i);
      if (i > LAST) i = LAST;
      return ramp[i];
    endfunction

    function void step_once();
      step_cnt++;
      if (dir) pos--;
      else pos++;
    endfunction

    function void begin_move(bit [31:0] travel);
      bit [31:0] mag;
      dir = travel[31];
      mag = travel[31] ? -travel : travel;
      total = mag;
      step_cnt = '0;
      timer_on = 1'b1;
      if (mag == 0) begin
        ph = PH_STOP;
        return;
      end
      moving = 1'b1;
      if (mag == 1) begin
        accel_lim = 1;
        decel_at = 0;
        ph = PH_DECEL;
        return;
      end
      reload = ramp_at(0);
      if (mag <= 2 * DEPTH) begin
        accel_lim = mag / 2;
        decel_at = accel_lim;
      end else begin
        accel_lim = DEPTH;
        decel_at = mag - DEPTH;
      end
      ph = PH_ACCEL;
    endfunction

    function void timer_tick();
      case (ph)
        PH_STOP: begin
          step_cnt = '0;
          timer_on = 1'b0;
          moving = 1'b0;
          stop_ticks++;
        end
        PH_ACCEL: begin
          step_once();
          if (step_cnt < accel_lim) begin
            reload = ramp_at(step_cnt);
          end else if (step_cnt >= decel_at) begin
            reload = ramp_at(step_cnt - 1);
            ph = PH_DECEL;
          end else if (step_cnt >= DEPTH) begin
            reload = ramp_at(LAST);
            ph = PH_RUN;
            run_entries++;
          end
        end
        PH_RUN: begin
          step_once();
          if (step_cnt >= decel_at) begin
            reload = ramp_at(LAST);
            ph = PH_DECEL;
          end
        end
        default: begin
          step_once();
          if (step_cnt < total) reload = ramp_at(total - step_cnt);
          else ph = PH_STOP;
        end
      endcase
    endfunction

    function void note_command(ramp_cmd_s c);
      ramp_state_s s;
      commands++;
      case (c.command)
        CMD_LOAD: if (c.table_index <= LAST) ramp[c.table_index] = c.table_value;
        CMD_TICK: timer_tick();
        default: begin
          moves++;
          begin_move(c.command == CMD_REL ? c.steps : c.steps - pos);
          if (total == 1) reload = c.single_step_reload;
        end
      endcase
      s.reload = reload;
      s.compare = reload[15:1];
      s.direction = dir;
      s.timer_on = timer_on;
      s.moving = moving;
      s.phase = ph;
      s.position = pos;
      expected_states.push_back(s);
    endfunction

    task check_state(ramp_state_s got);
      ramp_state_s e;
      checked++;
      if (expected_states.size() == 0) begin
        report("result with no transaction pending");
        return;
      end
      e = expected_states.pop_front();
      if (got.reload !== e.reload)
        report($sformatf("reload %h, expected %h", got.reload, e.reload));
      if (got.compare !== e.compare)
        report($sformatf("compare %h, expected %h", got.compare, e.compare));
      if (got.direction !== e.direction)
        report($sformatf("direction %b, expected %b", got.direction, e.direction));
      if (got.timer_on !== e.timer_on)
        report($sformatf("timer_on %b, expected %b", got.timer_on, e.timer_on));
      if (got.moving !== e.moving)
        report($sformatf("moving %b, expected %b", got.moving, e.moving));
      if (got.phase !== e.phase)
        report($sformatf("phase %0d, expected %0d", got.phase, e.phase));
      if (got.position !== e.position)
        report($sformatf("position %h, expected %h", got.position, e.position));
    endtask
  endclass

  logic clk;
  logic rst_n;

  scsr_in_if  in_if();
  scsr_out_if out_if();

  s_curve_stepper_ramp_core #(.RAMP_STEPS(RAMP_STEPS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  ramp_scoreboard #(RAMP_STEPS) ramp_sb;
  int burst_left;
  int issued;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  task automatic issue(cmd_t op, bit [7:0] idx, bit [15:0] val, bit [31:0] steps,
                       bit [15:0] single);
    ramp_cmd_s c;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    c.command = op;
    c.table_index = idx;
    c.table_value = val;
    c.steps = steps;
    c.single_step_reload = single;
    in_if.valid <= 1'b1;
    in_if.command <= op;
    in_if.table_index <= idx;
    in_if.table_value <= val;
    in_if.steps <= steps;
    in_if.single_step_reload <= single;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ramp_sb.note_command(c);
    issued++;
    @(negedge clk);
  endtask

  task automatic tick_n(int n);
    repeat (n) issue(CMD_TICK, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic move(bit absolute, bit [31:0] travel, bit [15:0] single);
    if (absolute) issue(CMD_ABS, 8'($urandom), 16'($urandom), ramp_sb.pos + travel, single);
    else issue(CMD_REL, 8'($urandom), 16'($urandom), travel, single);
  endtask

  // hold off the sender until every pending transaction has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (ramp_sb.expected_states.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: sample at the rising edge, change ready at the falling edge
  initial begin
    ramp_state_s got;
    int hold;
    int mode;
    out_if.ready = 1'b0;
    hold = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.reload = out_if.reload;
        got.compare = out_if.compare;
        got.direction = out_if.direction;
        got.timer_on = out_if.timer_on;
        got.moving = out_if.moving;
        got.phase = out_if.phase;
        got.position = out_if.position;
        ramp_sb.check_state(got);
      end
      @(negedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(16, 96);
      end
      hold--;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (hold % 10 == 0);
      endcase
    end
  end

  initial begin
    int base;
    int seq;
    int pick;
    int kind;
    int n;
    bit [31:0] mag;
    bit [31:0] travel;

    ramp_sb = new();
    burst_left = 0;
    issued = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.table_index = '0;
    in_if.table_value = '0;
    in_if.steps = '0;
    in_if.single_step_reload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stop-phase tick and zero-step move need no table entry
    tick_n(1);
    move(1'b0, 32'd0, 16'($urandom));
    tick_n(2);

    // fill the whole table before any move can read it
    for (int i = 0; i < RAMP_STEPS; i++) begin
      issue(CMD_LOAD, i[7:0], (i == 0) ? 16'hFFFF : (i == RAMP_STEPS - 1) ? 16'h0000
                                                  : 16'($urandom), $urandom, 16'($urandom));
    end

    // single step moves in both directions, then short moves of two and three steps
    move(1'b0, 32'd1, 16'hFFFF);
    tick_n(1);
    move(1'b0, 32'hFFFF_FFFF, 16'h0000);
    tick_n(2);
    move(1'b0, 32'd2, 16'($urandom));
    tick_n(3);
    move(1'b1, -32'sd3, 16'($urandom));
    tick_n(4);
    // most negative count and largest positive count, then a restart mid move
    move(1'b0, 32'h8000_0000, 16'($urandom));
    tick_n(2);
    move(1'b0, 32'h7FFF_FFFF, 16'($urandom));
    tick_n(1);
    issue(CMD_ABS, 8'($urandom), 16'($urandom), 32'h7FFF_FFFF, 16'($urandom));
    tick_n(1);
    move(1'b1, 32'd0, 16'($urandom));
    tick_n(2);
    issue(CMD_LOAD, 8'hFF, 16'hFFFF, $urandom, 16'($urandom));
    issue(CMD_LOAD, 8'h00, 16'h0000, $urandom, 16'($urandom));
    settle();

    base = issued;
    seq = 0;
    while (issued - base < 1800) begin
      seq++;
      if (seq % 30 == 0) settle();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          issue(CMD_LOAD, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
      end else if (pick < 13) begin
        tick_n($urandom_range(1, 3));
      end else begin
        kind = $urandom_range(0, 99);
        if (seq == 7 || seq == 40 || kind < 1) mag = $urandom_range(513, 560);
        else if (kind < 6) mag = $urandom_range(257, 512);
        else if (kind < 12) mag = $urandom;
        else if (kind < 14) mag = 32'h8000_0000;
        else mag = $urandom_range(0, 24);
        travel = $urandom_range(0, 1) ? -mag : mag;
        if (mag > 600) n = $urandom_range(1, 40);
        else if ($urandom_range(0, 6) == 0) n = $urandom_range(0, int'(mag));
        else n = int'(mag) + $urandom_range(1, 3);
        move(1'($urandom_range(0, 1)), travel, 16'($urandom));
        tick_n(n);
      end
    end

    in_if.valid <= 1'b0;
    while (ramp_sb.expected_states.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("tb: %0d transactions, %0d results checked, %0d moves",
             ramp_sb.commands, ramp_sb.checked, ramp_sb.moves);
    $display("tb: run phase entered %0d times, %0d ticks while stopped, %0d mismatches",
             ramp_sb.run_entries, ramp_sb.stop_ticks, ramp_sb.errors);
    if (ramp_sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
